// File: sv/bmcps_pkg.sv
// ----------------------------------------------------------------------------
// bmcps_pkg: shared types and constants
// Beat formats, configuration register indexes and geometry limits for the
// block minimum-cost point selector.
// ----------------------------------------------------------------------------
package bmcps_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxStep   = 16;
  localparam int unsigned CostBits  = 16;

  localparam int unsigned PosW      = $clog2(MaxWidth);      // 12
  localparam int unsigned DimW      = PosW + 1;              // 13
  localparam int unsigned InBlkW    = $clog2(MaxStep);       // 4
  localparam int unsigned StepW     = InBlkW + 1;            // 5
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DimW-1:0]     WidthReset     = DimW'(640);
  localparam logic [DimW-1:0]     HeightReset    = DimW'(480);
  localparam logic [StepW-1:0]    StepReset      = StepW'(5);
  localparam logic [CostBits-1:0] ThresholdReset = CostBits'(1638);
  localparam logic [CostBits-1:0] CapReset       = CostBits'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth      = 3'd0,
    RegImageHeight     = 3'd1,
    RegBlockStep       = 3'd2,
    RegAcceptThreshold = 3'd3,
    RegCostCap         = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CostBits-1:0] pixel_cost;
    logic                frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [PosW-1:0] point_col;
    logic [PosW-1:0] point_row;
  } out_beat_t;

  // one entry per block column
  typedef struct packed {
    logic                has_point;
    logic [CostBits-1:0] low_cost;
    logic [PosW-1:0]     best_col;
    logic [PosW-1:0]     best_row;
  } entry_t;

endpackage

// File: sv/block_min_cost_point_select.sv
// ----------------------------------------------------------------------------
// block_min_cost_point_select
// Per-block argmin over a raster cost stream, one point per accepted block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one pixel cost a
//   beat in raster order; frame_start forces the position to (0,0).
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries the selected
//   point of a block when its last pixel has passed and its minimum is below
//   accept_threshold. Blocks come out in raster block order.
//   Config port (cfg_we_i/cfg_idx_i/cfg_data_i) writes one register a cycle;
//   write only while the block is idle.
// Throughput: one pixel per cycle while in_ready_o is high. Each pixel does
//   one read-modify-write of its block-column entry in a 4096 x 41 bit RAM
//   (one read port, one write port); back-to-back hits on the same entry are
//   forwarded. A block's point is written into the output FIFO from stage 1
//   at the edge after the one that accepts its last pixel beat.
// Receiver stall: results queue in a 4-deep output FIFO; in_ready_o drops
//   only when the FIFO plus the result in flight could fill it.
// Reset: registers return to their defaults and the position to (0,0). The
//   RAM is not cleared; an entry is always rewritten by the first pixel of
//   its block before it is used.
// ----------------------------------------------------------------------------
module block_min_cost_point_select
  import bmcps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [DimW-1:0]     width_q, height_q;
  logic [StepW-1:0]    step_q;
  logic [CostBits-1:0] thr_q, cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      step_q   <= StepReset;
      thr_q    <= ThresholdReset;
      cap_q    <= CapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth:      width_q  <= cfg_data_i[DimW-1:0];
        RegImageHeight:     height_q <= cfg_data_i[DimW-1:0];
        RegBlockStep:       step_q   <= cfg_data_i[StepW-1:0];
        RegAcceptThreshold: thr_q    <= cfg_data_i[CostBits-1:0];
        RegCostCap:         cap_q    <= cfg_data_i[CostBits-1:0];
        default: ;
      endcase
    end
  end

  logic [DimW-1:0]  w_eff, h_eff;
  logic [StepW-1:0] s_eff;

  always_comb begin
    if (width_q == '0)                   w_eff = DimW'(1);
    else if (width_q > DimW'(MaxWidth))  w_eff = DimW'(MaxWidth);
    else                                 w_eff = width_q;
    if (height_q == '0)                  h_eff = DimW'(1);
    else if (height_q > DimW'(MaxWidth)) h_eff = DimW'(MaxWidth);
    else                                 h_eff = height_q;
    if (step_q == '0)                    s_eff = StepW'(1);
    else if (step_q > StepW'(MaxStep))   s_eff = StepW'(MaxStep);
    else                                 s_eff = step_q;
  end

  // --------------------------------------------------------------------------
  // position tracking (stage 0)
  // --------------------------------------------------------------------------
  logic [PosW-1:0]   cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [InBlkW-1:0] cib_q, cib_d, rib_q, rib_d;
  logic [PosW-1:0]   bcol_q, bcol_d;

  logic [PosW-1:0]   col0, row0, bc0;
  logic [InBlkW-1:0] cib0, rib0;
  logic              row_end, frame_end, blk_col_end, blk_row_end;
  logic              cib_wrap, rib_wrap;
  logic              in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    if (in_data_i.frame_start) begin
      col0 = '0;
      row0 = '0;
      cib0 = '0;
      rib0 = '0;
      bc0  = '0;
    end else begin
      col0 = cur_col_q;
      row0 = cur_row_q;
      cib0 = cib_q;
      rib0 = rib_q;
      bc0  = bcol_q;
    end

    row_end     = ({1'b0, col0} + DimW'(1)) >= w_eff;
    frame_end   = ({1'b0, row0} + DimW'(1)) >= h_eff;
    cib_wrap    = ({1'b0, cib0} + StepW'(1)) >= s_eff;
    rib_wrap    = ({1'b0, rib0} + StepW'(1)) >= s_eff;
    blk_col_end = row_end || cib_wrap;
    blk_row_end = frame_end || rib_wrap;

    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    cib_d     = cib_q;
    rib_d     = rib_q;
    bcol_d    = bcol_q;
    if (in_fire) begin
      if (row_end) begin
        cur_col_d = '0;
        cib_d     = '0;
        bcol_d    = '0;
        if (frame_end) begin
          cur_row_d = '0;
          rib_d     = '0;
        end else begin
          cur_row_d = row0 + PosW'(1);
          rib_d     = rib_wrap ? '0 : rib0 + InBlkW'(1);
        end
      end else begin
        cur_col_d = col0 + PosW'(1);
        cur_row_d = row0;
        rib_d     = rib0;
        if (cib_wrap) begin
          cib_d  = '0;
          bcol_d = bc0 + PosW'(1);
        end else begin
          cib_d  = cib0 + InBlkW'(1);
          bcol_d = bc0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      cib_q     <= '0;
      rib_q     <= '0;
      bcol_q    <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cib_q     <= cib_d;
      rib_q     <= rib_d;
      bcol_q    <= bcol_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: read-modify-write of the block-column entry
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [CostBits-1:0] s1_cost_q;
  logic [PosW-1:0]     s1_col_q, s1_row_q, s1_bc_q;
  logic                s1_first_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cost_q  <= in_data_i.pixel_cost;
      s1_col_q   <= col0;
      s1_row_q   <= row0;
      s1_bc_q    <= bc0;
      s1_first_q <= (cib0 == '0) && (rib0 == '0);
      s1_last_q  <= blk_col_end && blk_row_end;
    end
  end

  entry_t mem_q [MaxWidth];
  entry_t rd_q;
  entry_t fwd_q;
  logic   fwd_hit_q;
  entry_t old_ent, new_ent;
  logic   take, emit;

  always_comb begin
    old_ent = fwd_hit_q ? fwd_q : rd_q;
    // first pixel of a block starts from an empty entry
    if (s1_first_q) old_ent = '0;
    take = (s1_cost_q < cap_q) &&
           (!old_ent.has_point || (s1_cost_q < old_ent.low_cost) ||
            ((s1_cost_q == old_ent.low_cost) && (s1_col_q < old_ent.best_col)));
    if (take) begin
      new_ent.has_point = 1'b1;
      new_ent.low_cost  = s1_cost_q;
      new_ent.best_col  = s1_col_q;
      new_ent.best_row  = s1_row_q;
    end else begin
      new_ent = old_ent;
    end
    emit = s1_valid_q && s1_last_q && new_ent.has_point && (new_ent.low_cost < thr_q);
  end

  // read-first RAM; a write and a read of the same entry at one edge is forwarded
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) mem_q[s1_bc_q] <= new_ent;
    if (in_fire) begin
      rd_q      <= mem_q[bc0];
      fwd_q     <= new_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_q <= s1_valid_q && (s1_bc_q == bc0);
    end
  end

  // --------------------------------------------------------------------------
  // output FIFO
  // --------------------------------------------------------------------------
  out_beat_t           fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, occ;
  logic                out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign out_fire    = out_valid_o && out_ready_i;
  // room for the beat in flight plus the one taken now
  assign occ         = cnt_q + FifoCntW'(s1_valid_q);
  assign in_ready_o  = occ < FifoCntW'(FifoDepth);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      fifo_q[wr_ptr_q].point_col <= new_ent.best_col;
      fifo_q[wr_ptr_q].point_row <= new_ent.best_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (emit)     wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      if (out_fire) rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      cnt_q <= cnt_q + FifoCntW'(emit) - FifoCntW'(out_fire);
    end
  end

endmodule

// File: tb/sv/block_min_cost_point_select_tb.sv
// ----------------------------------------------------------------------------
// block_min_cost_point_select_tb: self-checking bench for the block selector
// Streams raster cost maps through the valid/ready input with bursty timing,
// keeps its own copy of the per-block-column minimum tracking, and compares
// every emitted point against the predicted order. The receiver stalls on
// its own random pattern and once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module block_min_cost_point_select_tb
  import bmcps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBeats = 800;

  // w=5 h=4 step=2 map: ties by column, ties by row, empty block, min equal
  // to threshold, clipped edge blocks
  localparam logic [CostBits-1:0] DirectedCosts [20] = '{
    16'h0064, 16'h0032, 16'h0046, 16'h001E, 16'hFFFF,
    16'h0032, 16'h0032, 16'h0046, 16'h001E, 16'h8000,
    16'h4000, 16'h7FFF, 16'h0000, 16'h0000, 16'h3FFF,
    16'h4001, 16'h5000, 16'h0000, 16'h0001, 16'h3FFF
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_beat_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  block_min_cost_point_select u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  // register copies
  logic [DimW-1:0]     geo_width  = WidthReset;
  logic [DimW-1:0]     geo_height = HeightReset;
  logic [StepW-1:0]    geo_step   = StepReset;
  logic [CostBits-1:0] thr_reg    = ThresholdReset;
  logic [CostBits-1:0] cap_reg    = CapReset;

  // scan position and per-block-column running minimum
  logic [PosW-1:0] pos_col = '0;
  logic [PosW-1:0] pos_row = '0;
  int unsigned     col_off = 0;
  int unsigned     row_off = 0;
  logic [PosW-1:0] blk_idx = '0;
  entry_t          col_entry [MaxWidth];

  in_beat_t    pixel_backlog [$];
  out_beat_t   points_due [$];
  out_beat_t   due_point;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  logic        hold_done    = 1'b0;
  logic        hold_off_req = 1'b0;

  int unsigned cycle_count        = 0;
  int unsigned pixels_taken       = 0;
  int unsigned points_seen        = 0;
  int unsigned settings_count     = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned mismatches         = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // advance the scan by one pixel, queue the point it completes (if any)
  function automatic void scan_pixel(in_beat_t px);
    int unsigned w;
    int unsigned h;
    int unsigned s;
    logic [PosW-1:0] bc;
    logic take;
    logic row_end;
    logic frame_end;
    logic blk_col_end;
    logic blk_row_end;
    out_beat_t pt;
    w = clamp_dim(geo_width, MaxWidth);
    h = clamp_dim(geo_height, MaxWidth);
    s = clamp_dim(geo_step, MaxStep);
    if (px.frame_start) begin
      pos_col = '0;
      pos_row = '0;
      col_off = 0;
      row_off = 0;
      blk_idx = '0;
    end
    bc = blk_idx;
    if (row_off == 0 && col_off == 0) col_entry[bc] = '0;
    if (px.pixel_cost < cap_reg) begin
      take = !col_entry[bc].has_point || px.pixel_cost < col_entry[bc].low_cost ||
             (px.pixel_cost == col_entry[bc].low_cost && pos_col < col_entry[bc].best_col);
      if (take) begin
        col_entry[bc] = '{has_point: 1'b1, low_cost: px.pixel_cost,
                          best_col: pos_col, best_row: pos_row};
      end
    end
    row_end     = (pos_col + 1) >= w;
    frame_end   = (pos_row + 1) >= h;
    blk_col_end = row_end || (col_off + 1) >= s;
    blk_row_end = frame_end || (row_off + 1) >= s;
    if (blk_col_end && blk_row_end && col_entry[bc].has_point &&
        col_entry[bc].low_cost < thr_reg) begin
      pt.point_col = col_entry[bc].best_col;
      pt.point_row = col_entry[bc].best_row;
      points_due.insert(points_due.size(), pt);
    end
    if (row_end) begin
      pos_col = '0;
      col_off = 0;
      blk_idx = '0;
      if (frame_end) begin
        pos_row = '0;
        row_off = 0;
      end else begin
        pos_row = pos_row + 1'b1;
        row_off = ((row_off + 1) >= s) ? 0 : row_off + 1;
      end
    end else begin
      pos_col = pos_col + 1'b1;
      if ((col_off + 1) >= s) begin
        col_off = 0;
        blk_idx = blk_idx + 1'b1;
      end else begin
        col_off = col_off + 1;
      end
    end
  endfunction

  // cost biased toward the current threshold and cap
  function automatic logic [CostBits-1:0] pick_cost();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        if (thr_reg == 0) return CostBits'($urandom);
        return CostBits'($urandom_range(thr_reg - 1, 0));
      end
      4, 5:    return CostBits'($urandom_range(7, 0));
      6:       return ($urandom_range(1, 0) != 0) ? cap_reg : cap_reg - 1'b1;
      7:       return CostBits'($urandom_range(16'hFFFF, cap_reg));
      default: return CostBits'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegImageWidth:      geo_width  = val[DimW-1:0];
      RegImageHeight:     geo_height = val[DimW-1:0];
      RegBlockStep:       geo_step   = val[StepW-1:0];
      RegAcceptThreshold: thr_reg    = val[CostBits-1:0];
      RegCostCap:         cap_reg    = val[CostBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] w, h, s, thr, cap);
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
    write_reg(RegBlockStep, s);
    write_reg(RegAcceptThreshold, thr);
    write_reg(RegCostCap, cap);
    settings_count++;
  endtask

  task automatic queue_pixel(input logic [CostBits-1:0] cost, input logic fs);
    in_beat_t px;
    px.pixel_cost  = cost;
    px.frame_start = fs;
    pixel_backlog.insert(pixel_backlog.size(), px);
  endtask

  // all beats sent, all points back, then let the pipe drain
  task automatic wait_idle();
    @(negedge clk_i);
    while (pixel_backlog.size() != 0 || in_valid_i || points_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // sender: bursts with gaps, payload held until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        scan_pixel(in_data_i);
        pixels_taken++;
      end
      if (in_valid_i && !in_ready_o) backpressure_cycles++;
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pixel_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pixel_backlog.pop_front();
          if (burst_left <= 1) begin
            if ($urandom_range(3, 0) == 0) begin
              burst_left <= $urandom_range(120, 20);
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(8, 1);
              gap_left   <= $urandom_range(10, 1);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: ready runs with short stalls, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_left  <= 0;
      stall_left  <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_off_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (ready_left != 0) begin
      out_ready_i <= 1'b1;
      ready_left  <= ready_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_left  <= ($urandom_range(7, 0) == 0) ? $urandom_range(150, 50)
                                                  : $urandom_range(20, 0);
      stall_left  <= ($urandom_range(3, 0) == 0) ? $urandom_range(12, 4)
                                                  : $urandom_range(2, 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      points_seen++;
      if (points_due.size() == 0) begin
        note_mismatch($sformatf("point col %0d row %0d with none due",
                                out_data_o.point_col, out_data_o.point_row));
      end else begin
        due_point = points_due.pop_front();
        if (out_data_o.point_col !== due_point.point_col)
          note_mismatch($sformatf("point_col %0d, want %0d",
                                  out_data_o.point_col, due_point.point_col));
        if (out_data_o.point_row !== due_point.point_row)
          note_mismatch($sformatf("point_row %0d, want %0d",
                                  out_data_o.point_row, due_point.point_row));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d points outstanding",
               cycle_count, points_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned fsz;
    int unsigned random_pixels;
    logic [CfgDataW-1:0] w_raw;
    logic [CfgDataW-1:0] h_raw;
    logic [CfgDataW-1:0] s_raw;
    logic [CfgDataW-1:0] thr_raw;
    logic [CfgDataW-1:0] cap_raw;
    logic fresh;
    logic fs;

    random_pixels = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed map, then wrap past frame end and a frame start mid-frame
    program_regs(16'd5, 16'd4, 16'd2, 16'h4000, 16'h8000);
    for (i = 0; i < 20; i++) queue_pixel(DirectedCosts[i], i == 0);
    queue_pixel(16'h0010, 1'b0);
    queue_pixel(16'h0020, 1'b0);
    queue_pixel(16'h0005, 1'b1);
    queue_pixel(16'h0006, 1'b0);
    wait_idle();

    // widest row, masked and clamped width, 1x1 blocks: touches every column
    program_regs(16'hFFFF, 16'd0, 16'd1, 16'h1000, 16'hFFFF);
    for (i = 0; i < MaxWidth; i++) queue_pixel(pick_cost(), i == 0);
    wait_idle();

    // tallest frame, zero width and step, then wrap into the next frame
    program_regs(16'd0, 16'h1FFF, 16'd0, 16'hFFFF, 16'hFFFF);
    for (i = 0; i < MaxWidth + 3; i++) queue_pixel(pick_cost(), i == 0);
    wait_idle();

    // oversized step clamps to the max, clipped blocks on both edges
    program_regs(16'd20, 16'd17, 16'hFFFF, 16'($urandom_range(16'h6000, 16'h0800)),
                 16'hC000);
    for (i = 0; i < 360; i++) queue_pixel(pick_cost(), i == 0);
    wait_idle();

    // geometry shrinks under a frame in progress: position lands past the edge
    program_regs(16'd20, 16'd12, 16'd4, 16'h2000, 16'hC000);
    for (i = 0; i < 276; i++) queue_pixel(pick_cost(), i == 0);
    wait_idle();
    write_reg(RegImageWidth, 16'd10);
    for (i = 0; i < 30; i++) queue_pixel(pick_cost(), 1'b0);
    wait_idle();
    write_reg(RegBlockStep, 16'd3);
    write_reg(RegImageHeight, 16'd2);
    for (i = 0; i < 40; i++) queue_pixel(pick_cost(), 1'b0);
    wait_idle();
    settings_count += 2;

    // every pixel yields a point; receiver holds off once, long enough to stall the input
    program_regs(16'd8, 16'd8, 16'd1, 16'hFFFF, 16'hFFFF);
    hold_off_req = 1'b1;
    for (i = 0; i < 200; i++) queue_pixel(CostBits'($urandom_range(16'hFFFE, 0)), i == 0);
    wait_idle();

    while (random_pixels < RandomBeats) begin
      case ($urandom_range(9, 0))
        0:       w_raw = 16'd0;
        1:       w_raw = 16'($urandom_range(40, 13));
        2:       w_raw = 16'($urandom);
        default: w_raw = 16'($urandom_range(12, 1));
      endcase
      case ($urandom_range(9, 0))
        0:       h_raw = 16'd0;
        1:       h_raw = 16'($urandom_range(20, 9));
        default: h_raw = 16'($urandom_range(8, 1));
      endcase
      case ($urandom_range(9, 0))
        0:       s_raw = 16'd0;
        1:       s_raw = 16'($urandom_range(31, 16));
        2:       s_raw = 16'($urandom_range(15, 7));
        default: s_raw = 16'($urandom_range(6, 1));
      endcase
      case ($urandom_range(7, 0))
        0:       thr_raw = 16'd0;
        1:       thr_raw = 16'hFFFF;
        2:       thr_raw = 16'($urandom);
        default: thr_raw = 16'($urandom_range(16'h6000, 16'h0100));
      endcase
      case ($urandom_range(7, 0))
        0:       cap_raw = 16'd0;
        1:       cap_raw = 16'hFFFF;
        2:       cap_raw = thr_raw;
        default: cap_raw = 16'($urandom_range(16'hFFFF, 16'h2000));
      endcase
      program_regs(w_raw, h_raw, s_raw, thr_raw, cap_raw);
      fsz = clamp_dim(geo_width, MaxWidth) * clamp_dim(geo_height, MaxWidth);
      n = (fsz <= 120) ? fsz * $urandom_range(3, 1) : $urandom_range(120, 40);
      // mostly clean frames; sometimes resume the old position or restart mid-frame
      fresh = ($urandom_range(9, 0) != 0);
      for (i = 0; i < n; i++) begin
        fs = (i == 0 && fresh) ||
             (i != 0 && i % fsz == 0 && $urandom_range(1, 0) != 0) ||
             ($urandom_range(59, 0) == 0);
        queue_pixel(pick_cost(), fs);
      end
      random_pixels += n;
      wait_idle();
    end

    $display("Run covered %0d pixel beats over %0d register settings, %0d points checked.",
             pixels_taken, settings_count, points_seen);
    $display("Input held off by a full output path on %0d cycles.", backpressure_cycles);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bmcps_pkg.sv
sv/block_min_cost_point_select.sv
tb/sv/block_min_cost_point_select_tb.sv
